### rtl/core/keyed_event_throttle_core_macros.svh
`ifndef KEYED_EVENT_THROTTLE_CORE_MACROS_SVH
`define KEYED_EVENT_THROTTLE_CORE_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define KET_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define KET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ket_pkg.sv
`default_nettype none

package ket_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [31:0] WINDOW_RST = 32'd600;
  localparam logic [11:0] QUIET_RST  = 12'hFFF;

  typedef struct packed {
    logic [2:0]  category;
    logic [63:0] key_sig;
    logic [31:0] now_seconds;
    logic [10:0] minute_of_day;
  } ket_in_t;

  typedef struct packed {
    logic deliver;
    logic throttled;
    logic quiet;
  } ket_out_t;

  typedef struct packed {
    logic [2:0]  category;
    logic [63:0] key_sig;
    logic [31:0] fired_at;
  } ket_slot_t;

  typedef struct packed {
    logic      shift;
    logic      load;
    ket_slot_t data;
  } ket_ring_ctl_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW = 2'd0,
    CFG_QSTART = 2'd1,
    CFG_QEND   = 2'd2
  } ket_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE,
    ST_FILL
  } ket_state_e;

endpackage

`default_nettype wire

### rtl/core/ket_cell.sv
`default_nettype none

module ket_cell import ket_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      shift_i,
  input  ket_slot_t slot_i,
  output ket_slot_t slot_o
);

  ket_slot_t slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (shift_i) begin
      slot_q <= slot_i;
    end
  end

  assign slot_o = slot_q;

endmodule

`default_nettype wire

### rtl/core/ket_ctrl.sv
`default_nettype none

module ket_ctrl import ket_pkg::*; #(
  parameter int unsigned SLOTS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  ket_in_t       evt_i,
  input  logic [31:0]   window_i,
  input  logic [11:0]   quiet_start_i,
  input  logic [11:0]   quiet_end_i,
  input  ket_slot_t     head_i,
  output ket_ring_ctl_t ring_o,
  output logic          res_valid_o,
  output ket_out_t      res_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  ket_state_e      state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] victim_q, victim_d;
  ket_in_t         item_q;
  logic            found_q, found_d;
  logic            thr_q, thr_d;
  logic            quiet_q, quiet_d;

  logic            accept;
  logic            cnt_last;
  logic [IdxW-1:0] cnt_inc;
  logic            head_match;
  logic            head_thr;
  logic [31:0]     age;
  logic            deliver;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign cnt_last = (cnt_q == LastIdx);
  assign cnt_inc  = cnt_last ? '0 : cnt_q + 1'b1;
  assign deliver  = !thr_q && !quiet_q;

  always_comb begin
    quiet_d = 1'b0;
    if (!quiet_start_i[11] && !quiet_end_i[11] && (quiet_start_i != quiet_end_i)) begin
      if (quiet_start_i[10:0] < quiet_end_i[10:0]) begin
        quiet_d = (evt_i.minute_of_day >= quiet_start_i[10:0]) &&
                  (evt_i.minute_of_day <  quiet_end_i[10:0]);
      end else begin
        quiet_d = (evt_i.minute_of_day >= quiet_start_i[10:0]) ||
                  (evt_i.minute_of_day <  quiet_end_i[10:0]);
      end
    end
  end

  always_comb begin
    head_match = (head_i.category == item_q.category) &&
                 (head_i.key_sig == item_q.key_sig);
    age        = item_q.now_seconds - head_i.fired_at;
    head_thr   = (window_i != '0) && (head_i.fired_at != '0) &&
                 ((item_q.now_seconds < head_i.fired_at) || (age < window_i));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_SCAN;
      ST_SCAN: if (cnt_last) state_d = ST_DONE;
      ST_DONE: state_d = (deliver && !found_q) ? ST_FILL : ST_IDLE;
      ST_FILL: if (cnt_last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o      = (state_q != ST_IDLE);
    res_valid_o = (state_q == ST_DONE);
    res_o       = '{deliver: deliver, throttled: thr_q, quiet: quiet_q};
    ring_o.shift = 1'b0;
    ring_o.load  = 1'b0;
    ring_o.data  = '{category: item_q.category,
                     key_sig:  item_q.key_sig,
                     fired_at: item_q.now_seconds};
    unique case (state_q)
      ST_SCAN: begin
        ring_o.shift = 1'b1;
        ring_o.load  = !found_q && head_match && !head_thr && !quiet_q;
      end
      ST_FILL: begin
        ring_o.shift = 1'b1;
        ring_o.load  = (cnt_q == victim_q);
      end
      default: begin
        ring_o.shift = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_d    = cnt_q;
    found_d  = found_q;
    thr_d    = thr_q;
    victim_d = victim_q;
    if (accept) begin
      cnt_d   = '0;
      found_d = 1'b0;
      thr_d   = 1'b0;
    end
    if (state_q == ST_SCAN) begin
      cnt_d = cnt_inc;
      if (!found_q && head_match) begin
        found_d = 1'b1;
        thr_d   = head_thr;
      end
    end
    if (state_q == ST_FILL) begin
      cnt_d = cnt_inc;
      if (cnt_last) begin
        victim_d = (victim_q == LastIdx) ? '0 : victim_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      victim_q <= '0;
      found_q  <= 1'b0;
      thr_q    <= 1'b0;
      quiet_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      victim_q <= victim_d;
      found_q  <= found_d;
      thr_q    <= thr_d;
      if (accept) begin
        quiet_q <= quiet_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= evt_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/keyed_event_throttle_core.sv
// Keyed event throttle. Raise start with an event on evt_i while busy is low;
// the event is taken at that edge. After one rotation, res_valid_o is high
// for exactly one cycle with deliver, throttled and quiet on res_o; the
// receiver cannot stall, so capture the result in that cycle. The slot table
// is a ring of SLOTS cells that rotates one slot per cycle past the head cell,
// where the compare and the refresh of a matching slot take place: an item
// that matches a slot or is not delivered ends after one rotation, and a
// delivered item with a new key takes a second rotation that writes the
// round-robin victim slot. busy stays high until the ring is back in place.
// Configuration writes are always accepted (cfg_ready_o is tied high) and
// must be issued only while busy is low.
`default_nettype none

module keyed_event_throttle_core import ket_pkg::*; #(
  parameter int unsigned SLOTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ket_in_t            evt_i,
  output logic               res_valid_o,
  output ket_out_t           res_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  logic [31:0]   window_q;
  logic [11:0]   qstart_q;
  logic [11:0]   qend_q;
  ket_slot_t     ring [SLOTS];
  ket_ring_ctl_t ring_ctl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RST;
      qstart_q <= QUIET_RST;
      qend_q   <= QUIET_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ket_cfg_e'(cfg_index_i))
        CFG_WINDOW: window_q <= cfg_data_i;
        CFG_QSTART: qstart_q <= cfg_data_i[11:0];
        CFG_QEND:   qend_q   <= cfg_data_i[11:0];
        default: begin
          window_q <= window_q;
        end
      endcase
    end
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    ket_slot_t cell_in;
    if (i == SLOTS - 1) begin : g_tail
      assign cell_in = ring_ctl.load ? ring_ctl.data : ring[0];
    end else begin : g_body
      assign cell_in = ring[i+1];
    end
    ket_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ring_ctl.shift),
      .slot_i  (cell_in),
      .slot_o  (ring[i])
    );
  end

  ket_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .evt_i         (evt_i),
    .window_i      (window_q),
    .quiet_start_i (qstart_q),
    .quiet_end_i   (qend_q),
    .head_i        (ring[0]),
    .ring_o        (ring_ctl),
    .res_valid_o   (res_valid_o),
    .res_o         (res_o)
  );

endmodule

`default_nettype wire

### rtl/core/ket_checker.sv
`default_nettype none

`include "keyed_event_throttle_core_macros.svh"

module ket_checker import ket_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     res_valid_o,
  input ket_out_t res_o
);

  logic deliver_ok;

  assign deliver_ok = (res_o.deliver == !(res_o.throttled || res_o.quiet));

  `KET_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted event did not raise busy")
  `KET_ASSERT_NEXT(a_strobe_single, res_valid_o, !res_valid_o, "result strobe held two cycles")
  `KET_ASSERT_SAME(a_strobe_busy, res_valid_o, busy, "result strobe while idle")
  `KET_ASSERT_SAME(a_deliver_rule, res_valid_o, deliver_ok, "deliver inconsistent")

endmodule

bind keyed_event_throttle_core ket_checker u_ket_checker (.*);

`default_nettype wire
